// ===== rtl/sbeq_pkg.sv =====
// Shared constants and command codes for the stereo cascaded biquad equalizer.
// No dependencies; used by rtl/stereo_cascaded_biquad_eq.sv through scoped names.
package sbeq_pkg;

  // Command codes carried on the command field
  typedef enum logic [1:0] {
    CMD_PROCESS = 2'd0,
    CMD_WRITE   = 2'd1,
    CMD_READ    = 2'd2
  } cmd_t;

  // Result kinds
  localparam logic KIND_PAIR     = 1'b0;
  localparam logic KIND_READBACK = 1'b1;

  // Storage layout
  localparam int COEFS_PER_BAND = 5;
  localparam int HIST_PER_BAND  = 8;

  // History word offsets within one channel of one band
  localparam logic [1:0] HW_X1 = 2'd0;
  localparam logic [1:0] HW_X2 = 2'd1;
  localparam logic [1:0] HW_Y1 = 2'd2;
  localparam logic [1:0] HW_Y2 = 2'd3;

  // Q15 scaling and output saturation limits
  localparam int Q_SHIFT = 15;
  localparam int SAT_HI  = 32767;
  localparam int SAT_LO  = -32768;

  // Multiply-accumulate sequencer steps within one section
  localparam logic [2:0] ST_ISSUE  = 3'd0;
  localparam logic [2:0] ST_TERM0  = 3'd1;
  localparam logic [2:0] ST_FIRST  = 3'd2;
  localparam logic [2:0] ST_H0WR   = 3'd3;
  localparam logic [2:0] ST_H2WR   = 3'd4;
  localparam logic [2:0] ST_SUB0   = 3'd5;
  localparam logic [2:0] ST_LAST   = 3'd6;

endpackage

// ===== rtl/stereo_cascaded_biquad_eq.sv =====
// Stereo cascaded direct-form-1 biquad equalizer, one shared 32x32 multiplier.
// Depends on rtl/sbeq_pkg.sv (command codes, layout and scaling constants).
//
// A process transaction runs every band and channel as a seven-step
// sequence on the single multiplier and accumulator, five products
// pipelined behind one-read, one-write coefficient and history memories.
// A coefficient write gives no result. The input side is ready only while
// the sequencer is idle; a finished result waits in the output register
// and does not block new transactions until the next result needs that
// register. Reset takes effect at once through per-word valid bits on the
// coefficients and per-band valid bits on the history, so no clearing pass
// is needed.
module stereo_cascaded_biquad_eq #(
  parameter int NUM_BANDS = 12
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         command,
  input  logic signed [15:0] in_left,
  input  logic signed [15:0] in_right,
  input  logic [3:0]         band_index,
  input  logic [2:0]         coeff_select,
  input  logic signed [31:0] coeff_value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               result_kind,
  output logic signed [15:0] out_left,
  output logic signed [15:0] out_right,
  output logic signed [31:0] read_value
);

  localparam int BAND_W     = (NUM_BANDS > 1) ? $clog2(NUM_BANDS) : 1;
  localparam int COEF_DEPTH = sbeq_pkg::COEFS_PER_BAND * NUM_BANDS;
  localparam int CA_W       = $clog2(COEF_DEPTH);
  localparam int HIST_DEPTH = sbeq_pkg::HIST_PER_BAND * NUM_BANDS;
  localparam int HA_W       = BAND_W + 3;
  localparam int PROD_MSB   = sbeq_pkg::Q_SHIFT + 31;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_RUN    = 4'b0010,
    S_RDWAIT = 4'b0100,
    S_DONE   = 4'b1000
  } state_t;

  state_t state;

  // Memories and their valid bits
  logic [31:0]           coef_mem [COEF_DEPTH];
  logic [31:0]           hist_mem [HIST_DEPTH];
  logic [COEF_DEPTH-1:0] coef_vld;
  logic [NUM_BANDS-1:0]  hist_vld;

  logic [31:0] coef_rdata, hist_rdata;
  logic        coef_rvld, hist_rvld;
  logic [CA_W-1:0] coef_raddr, in_caddr, run_caddr;
  logic [HA_W-1:0] hist_raddr, hist_waddr;
  logic            hist_we;
  logic [31:0]     hist_wdata;

  // Sequencer and datapath registers
  logic [BAND_W-1:0]  band_cnt;
  logic               ch;
  logic [2:0]         step;
  logic [31:0]        x_left, x_right;
  logic signed [63:0] prod;
  logic [31:0]        acc;
  logic               req_kind;
  logic               rd_ok;
  logic [31:0]        rd_val;

  logic signed [31:0] coef_rd_m, hist_rd_m, op_b;
  logic [31:0]        x_cur, term, acc_base, acc_next;
  logic [BAND_W-1:0]  in_band;
  logic [BAND_W+2:0]  in_sum, run_sum;
  logic               addr_ok, accept, out_free;

  // Decode the addressed coefficient
  assign in_band  = BAND_W'(band_index);
  assign addr_ok  = (int'(band_index) < NUM_BANDS) &&
                    (int'(coeff_select) < sbeq_pkg::COEFS_PER_BAND);
  assign in_sum   = {in_band, 2'b00} + (BAND_W+3)'(in_band) + (BAND_W+3)'(coeff_select);
  assign in_caddr = CA_W'(in_sum);
  assign run_sum  = {band_cnt, 2'b00} + (BAND_W+3)'(band_cnt) + (BAND_W+3)'(step);
  assign run_caddr = CA_W'(run_sum);
  assign coef_raddr = (state == S_RUN) ? run_caddr : in_caddr;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  // Coefficient memory: one write, one registered read
  always_ff @(posedge clk) begin
    if (accept && command == sbeq_pkg::CMD_WRITE && addr_ok) begin
      coef_mem[in_caddr] <= coeff_value;
    end
    coef_rdata <= coef_mem[coef_raddr];
  end

  // History addressing: band, channel, word
  always_comb begin
    hist_raddr = {band_cnt, ch, sbeq_pkg::HW_X1};
    hist_waddr = {band_cnt, ch, sbeq_pkg::HW_X1};
    hist_we    = 1'b0;
    hist_wdata = x_cur;
    if (state == S_RUN) begin
      unique case (step)
        sbeq_pkg::ST_TERM0: hist_raddr = {band_cnt, ch, sbeq_pkg::HW_X1};
        sbeq_pkg::ST_FIRST: begin
          hist_raddr = {band_cnt, ch, sbeq_pkg::HW_X2};
          hist_waddr = {band_cnt, ch, sbeq_pkg::HW_X2};
          hist_wdata = hist_rd_m;
          hist_we    = 1'b1;
        end
        sbeq_pkg::ST_H0WR: begin
          hist_raddr = {band_cnt, ch, sbeq_pkg::HW_Y1};
          hist_waddr = {band_cnt, ch, sbeq_pkg::HW_X1};
          hist_wdata = x_cur;
          hist_we    = 1'b1;
        end
        sbeq_pkg::ST_H2WR: begin
          hist_raddr = {band_cnt, ch, sbeq_pkg::HW_Y2};
          hist_waddr = {band_cnt, ch, sbeq_pkg::HW_Y2};
          hist_wdata = hist_rd_m;
          hist_we    = 1'b1;
        end
        sbeq_pkg::ST_LAST: begin
          hist_waddr = {band_cnt, ch, sbeq_pkg::HW_Y1};
          hist_wdata = acc_next;
          hist_we    = 1'b1;
        end
        default: ;
      endcase
    end
  end

  // History memory: one write, one registered read (read sees old data)
  always_ff @(posedge clk) begin
    if (hist_we) begin
      hist_mem[hist_waddr] <= hist_wdata;
    end
    hist_rdata <= hist_mem[hist_raddr];
  end

  // Register valid bits alongside the read data
  always_ff @(posedge clk) begin
    coef_rvld <= coef_vld[coef_raddr];
    hist_rvld <= hist_vld[band_cnt];
  end

  // Mask words never written since reset or band clear
  assign coef_rd_m = coef_rvld ? coef_rdata : 32'sd0;
  assign hist_rd_m = hist_rvld ? hist_rdata : 32'sd0;
  assign x_cur     = ch ? x_right : x_left;
  assign op_b      = (step == sbeq_pkg::ST_TERM0) ? x_cur : hist_rd_m;

  // Scale the product and accumulate; feedback terms subtract
  assign term     = prod[PROD_MSB:sbeq_pkg::Q_SHIFT];
  assign acc_base = (step == sbeq_pkg::ST_FIRST) ? 32'd0 : acc;
  assign acc_next = (step >= sbeq_pkg::ST_SUB0) ? (acc_base - term) : (acc_base + term);

  // Shared multiplier and accumulator
  always_ff @(posedge clk) begin
    if (state == S_RUN) begin
      if (step >= sbeq_pkg::ST_TERM0 && step <= sbeq_pkg::ST_SUB0) begin
        prod <= coef_rd_m * op_b;
      end
      if (step >= sbeq_pkg::ST_FIRST) begin
        acc <= acc_next;
      end
    end
  end

  function automatic logic [15:0] sat16(input logic [31:0] v);
    logic [15:0] r;
    if ($signed(v) > sbeq_pkg::SAT_HI) begin
      r = 16'h7fff;
    end else if ($signed(v) < sbeq_pkg::SAT_LO) begin
      r = 16'h8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

  // Sequencer, valid bits and channel registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      coef_vld <= '0;
      hist_vld <= '0;
      band_cnt <= '0;
      ch       <= 1'b0;
      step     <= sbeq_pkg::ST_ISSUE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            req_kind <= (command == sbeq_pkg::CMD_READ) ? sbeq_pkg::KIND_READBACK
                                                        : sbeq_pkg::KIND_PAIR;
            rd_ok    <= addr_ok;
            unique case (command)
              sbeq_pkg::CMD_PROCESS: begin
                x_left   <= {{16{in_left[15]}}, in_left};
                x_right  <= {{16{in_right[15]}}, in_right};
                band_cnt <= '0;
                ch       <= 1'b0;
                step     <= sbeq_pkg::ST_ISSUE;
                state    <= S_RUN;
              end
              sbeq_pkg::CMD_WRITE: begin
                if (addr_ok) begin
                  coef_vld[in_caddr] <= 1'b1;
                  hist_vld[in_band]  <= 1'b0;
                end
              end
              sbeq_pkg::CMD_READ: state <= S_RDWAIT;
              default: ;
            endcase
          end
        end
        S_RUN: begin
          if (step == sbeq_pkg::ST_LAST) begin
            if (ch) begin
              x_right <= acc_next;
            end else begin
              x_left  <= acc_next;
            end
            step <= sbeq_pkg::ST_ISSUE;
            ch   <= ~ch;
            // Advance to the next band after the right channel
            if (ch) begin
              hist_vld[band_cnt] <= 1'b1;
              if (int'(band_cnt) == NUM_BANDS - 1) begin
                state <= S_DONE;
              end else begin
                band_cnt <= band_cnt + 1'b1;
              end
            end
          end else begin
            step <= step + 3'd1;
          end
        end
        S_RDWAIT: begin
          rd_val <= rd_ok ? coef_rd_m : 32'd0;
          state  <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Output register: load the finished result, drop it when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      result_kind <= req_kind;
      if (req_kind == sbeq_pkg::KIND_READBACK) begin
        out_left   <= 16'sd0;
        out_right  <= 16'sd0;
        read_value <= rd_val;
      end else begin
        out_left   <= sat16(x_left);
        out_right  <= sat16(x_right);
        read_value <= 32'sd0;
      end
    end
  end

endmodule

// ===== tb/sbeq_tb_pkg.sv =====
// Testbench types, constants and the scoreboard for the stereo biquad equalizer.
// Depends on rtl/sbeq_pkg.sv for command codes, result kinds and layout constants.
package sbeq_tb_pkg;
  import sbeq_pkg::*;

  localparam int NUM_BANDS = 12;

  // Command code that the block ignores
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  // Coefficient select codes within one band
  localparam logic [2:0] SEL_B0 = 3'd0;
  localparam logic [2:0] SEL_B1 = 3'd1;
  localparam logic [2:0] SEL_B2 = 3'd2;
  localparam logic [2:0] SEL_A1 = 3'd3;
  localparam logic [2:0] SEL_A2 = 3'd4;

  typedef struct {
    logic [1:0]         command;
    logic signed [15:0] left;
    logic signed [15:0] right;
    logic [3:0]         band;
    logic [2:0]         sel;
    logic signed [31:0] value;
  } eq_item_t;

  typedef struct {
    logic               kind;
    logic signed [15:0] left;
    logic signed [15:0] right;
    logic signed [31:0] readback;
  } eq_result_t;

  class eq_scoreboard;
    logic [31:0] coef_mem [NUM_BANDS*COEFS_PER_BAND];
    logic [31:0] hist_mem [NUM_BANDS*HIST_PER_BAND];
    eq_result_t  pending_outputs [$];
    int          error_count;
    int          accepted_count;

    function new();
      foreach (coef_mem[i]) coef_mem[i] = '0;
      foreach (hist_mem[i]) hist_mem[i] = '0;
      error_count = 0;
      accepted_count = 0;
    endfunction

    // Q15 product: full 64-bit product, arithmetic shift, keep the low word
    function logic [31:0] q15_product(logic [31:0] c, logic [31:0] v);
      logic signed [63:0] prod;
      logic signed [63:0] shifted;
      prod = $signed(c) * $signed(v);
      shifted = prod >>> Q_SHIFT;
      return shifted[31:0];
    endfunction

    // One direct-form-1 section of one channel; advance its history
    function logic [31:0] run_band(int band, int ch, logic [31:0] x);
      int cb;
      int hb;
      logic [31:0] y;
      cb = band * COEFS_PER_BAND;
      hb = band * HIST_PER_BAND + ch * 4;
      y = q15_product(coef_mem[cb + SEL_B0], x)
        + q15_product(coef_mem[cb + SEL_B1], hist_mem[hb + HW_X1])
        + q15_product(coef_mem[cb + SEL_B2], hist_mem[hb + HW_X2])
        - q15_product(coef_mem[cb + SEL_A1], hist_mem[hb + HW_Y1])
        - q15_product(coef_mem[cb + SEL_A2], hist_mem[hb + HW_Y2]);
      hist_mem[hb + HW_X2] = hist_mem[hb + HW_X1];
      hist_mem[hb + HW_X1] = x;
      hist_mem[hb + HW_Y2] = hist_mem[hb + HW_Y1];
      hist_mem[hb + HW_Y1] = y;
      return y;
    endfunction

    function logic [15:0] clamp16(logic [31:0] v);
      logic signed [31:0] s;
      s = v;
      if (s > SAT_HI) return 16'(SAT_HI);
      if (s < SAT_LO) return 16'(SAT_LO);
      return s[15:0];
    endfunction

    // Update the model state for one accepted transaction; queue its result
    function void note_transaction(eq_item_t it);
      eq_result_t exp_res;
      logic [31:0] l;
      logic [31:0] r;
      bit addr_ok;
      int idx;
      accepted_count++;
      addr_ok = (it.band < NUM_BANDS) && (it.sel < COEFS_PER_BAND);
      idx = it.band * COEFS_PER_BAND + it.sel;
      case (it.command)
        CMD_PROCESS: begin
          l = {{16{it.left[15]}}, it.left};
          r = {{16{it.right[15]}}, it.right};
          for (int b = 0; b < NUM_BANDS; b++) begin
            l = run_band(b, 0, l);
            r = run_band(b, 1, r);
          end
          exp_res.kind = KIND_PAIR;
          exp_res.left = clamp16(l);
          exp_res.right = clamp16(r);
          exp_res.readback = '0;
          pending_outputs.push_back(exp_res);
        end
        CMD_WRITE: begin
          // Store the word and clear the band's history in both channels
          if (addr_ok) begin
            coef_mem[idx] = it.value;
            for (int k = 0; k < HIST_PER_BAND; k++)
              hist_mem[it.band * HIST_PER_BAND + k] = '0;
          end
        end
        CMD_READ: begin
          exp_res.kind = KIND_READBACK;
          exp_res.left = '0;
          exp_res.right = '0;
          exp_res.readback = addr_ok ? coef_mem[idx] : '0;
          pending_outputs.push_back(exp_res);
        end
        default: begin
          // drop: unused command changes nothing
        end
      endcase
    endfunction

    // Compare one delivered result with the oldest expected one
    function void check_result(eq_result_t got);
      eq_result_t want;
      if (pending_outputs.size() == 0) begin
        error_count++;
        if (error_count <= 10)
          $display("unexpected result: kind=%0d left=%0d right=%0d value=%0d",
                   got.kind, got.left, got.right, got.readback);
        return;
      end
      want = pending_outputs.pop_front();
      if (got.kind !== want.kind || got.left !== want.left ||
          got.right !== want.right || got.readback !== want.readback) begin
        error_count++;
        if (error_count <= 10)
          $display("mismatch: expected kind=%0d left=%0d right=%0d value=%0d, got kind=%0d left=%0d right=%0d value=%0d",
                   want.kind, want.left, want.right, want.readback,
                   got.kind, got.left, got.right, got.readback);
      end
    endfunction
  endclass

endpackage

// ===== tb/stereo_cascaded_biquad_eq_test.sv =====
// Top-level testbench for stereo_cascaded_biquad_eq: directed and random stimulus,
// random input bursts and output stalls. Depends on rtl/sbeq_pkg.sv and tb/sbeq_tb_pkg.sv.
module stereo_cascaded_biquad_eq_test;
  import sbeq_pkg::*;
  import sbeq_tb_pkg::*;

  localparam int ITEM_TARGET = 1850;
  localparam int CYCLE_LIMIT = 10000000;
  localparam int HOLD_CYCLES = 2500;
  localparam int TAIL_CYCLES = 200;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_ready;
  logic [1:0]         command;
  logic signed [15:0] in_left;
  logic signed [15:0] in_right;
  logic [3:0]         band_index;
  logic [2:0]         coeff_select;
  logic signed [31:0] coeff_value;
  logic               out_valid;
  logic               out_ready;
  logic               result_kind;
  logic signed [15:0] out_left;
  logic signed [15:0] out_right;
  logic signed [31:0] read_value;

  eq_scoreboard sb = new();

  int issued_items = 0;
  int burst_left = 0;

  stereo_cascaded_biquad_eq #(.NUM_BANDS(NUM_BANDS)) dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .command(command), .in_left(in_left), .in_right(in_right),
    .band_index(band_index), .coeff_select(coeff_select), .coeff_value(coeff_value),
    .out_valid(out_valid), .out_ready(out_ready),
    .result_kind(result_kind), .out_left(out_left), .out_right(out_right),
    .read_value(read_value)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Samples: mostly full range, some small, some at the extremes
  function automatic logic signed [15:0] rand_sample();
    int k;
    k = $urandom_range(0, 19);
    if (k < 14) return 16'($urandom);
    if (k < 17) return 16'($urandom_range(0, 511)) - 16'd256;
    if (k == 17) return 16'sh7FFF;
    if (k == 18) return 16'sh8000;
    return {16{1'($urandom_range(0, 1))}};
  endfunction

  // Coefficients: mostly within +-1.0 or near unity, some full range and extremes
  function automatic logic signed [31:0] rand_coef();
    int k;
    k = $urandom_range(0, 19);
    if (k < 10) return 32'($urandom_range(0, 65535)) - 32'd32768;
    if (k < 14) return 32'd32768 + 32'($urandom_range(0, 4095)) - 32'd2048;
    if (k < 18) return $urandom;
    if (k == 18) return 32'sh7FFFFFFF;
    return 32'sh80000000;
  endfunction

  function automatic eq_item_t random_item();
    eq_item_t it;
    it.command = 2'($urandom_range(0, 3));
    it.left = rand_sample();
    it.right = rand_sample();
    it.band = 4'($urandom_range(0, 15));
    it.sel = 3'($urandom_range(0, 7));
    it.value = $urandom;
    return it;
  endfunction

  function automatic bit is_effective(eq_item_t it);
    if (it.command == CMD_PROCESS || it.command == CMD_READ) return 1'b1;
    return it.command == CMD_WRITE && it.band < NUM_BANDS && it.sel < COEFS_PER_BAND;
  endfunction

  // Offer one transaction in bursts with random gaps; called and returns at negedge
  task automatic send(input eq_item_t it);
    int k;
    int gap;
    if (burst_left == 0) begin
      k = $urandom_range(0, 9);
      if (k < 4) gap = 0;
      else if (k < 8) gap = $urandom_range(1, 12);
      else if (k == 8) gap = $urandom_range(13, 80);
      else gap = $urandom_range(81, 200);
      if (gap > 0) begin
        in_valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    in_valid = 1'b1;
    command = it.command;
    in_left = it.left;
    in_right = it.right;
    band_index = it.band;
    coeff_select = it.sel;
    coeff_value = it.value;
    do @(posedge clk); while (!in_ready);
    sb.note_transaction(it);
    if (is_effective(it)) issued_items++;
    @(negedge clk);
  endtask

  task automatic write_coef(input int band, input int sel, input logic [31:0] value);
    eq_item_t it;
    it = random_item();
    it.command = CMD_WRITE;
    it.band = 4'(band);
    it.sel = 3'(sel);
    it.value = value;
    send(it);
  endtask

  task automatic read_coef(input int band, input int sel);
    eq_item_t it;
    it = random_item();
    it.command = CMD_READ;
    it.band = 4'(band);
    it.sel = 3'(sel);
    send(it);
  endtask

  task automatic process_pair(input logic [15:0] l, input logic [15:0] r);
    eq_item_t it;
    it = random_item();
    it.command = CMD_PROCESS;
    it.left = l;
    it.right = r;
    send(it);
  endtask

  // Hold the input side idle until every expected result has arrived
  task automatic wait_for_drain();
    in_valid = 1'b0;
    while (sb.pending_outputs.size() != 0) @(negedge clk);
  endtask

  // Stimulus
  initial begin
    eq_item_t it;
    bit paused;
    int n;
    paused = 1'b0;
    rst = 1'b1;
    in_valid = 1'b0;
    command = CMD_PROCESS;
    in_left = '0;
    in_right = '0;
    band_index = '0;
    coeff_select = '0;
    coeff_value = '0;
    repeat (5) @(negedge clk);
    rst = 1'b0;

    // Directed: zero coefficients, extremes, range checks, unused command
    process_pair(16'sh7FFF, 16'sh8000);
    read_coef(0, SEL_B0);
    write_coef(0, SEL_B0, 32'sh7FFFFFFF);
    read_coef(0, SEL_B0);
    write_coef(NUM_BANDS - 1, SEL_A2, 32'sh80000000);
    read_coef(NUM_BANDS - 1, SEL_A2);
    write_coef(NUM_BANDS, SEL_B0, 32'sh00008000);
    read_coef(NUM_BANDS, SEL_B0);
    write_coef(15, 7, 32'shFFFFFFFF);
    write_coef(3, 5, 32'sh00004000);
    read_coef(3, 7);
    read_coef(15, SEL_A2);
    it = random_item();
    it.command = CMD_UNUSED;
    send(it);
    process_pair(16'sh8000, 16'sh7FFF);
    process_pair(16'sh0000, 16'sh0000);
    process_pair(16'shFFFF, 16'sh0001);
    write_coef(5, SEL_A1, 32'sh0000C000);
    read_coef(5, SEL_A1);
    write_coef(5, SEL_B1, 32'sh00000000);
    read_coef(5, SEL_B1);
    process_pair(16'sh1234, 16'shEDCB);

    // Random: mostly programmed filters streaming audio, some noise
    n = 0;
    while (issued_items < ITEM_TARGET) begin
      if (!paused && issued_items >= 900) begin
        wait_for_drain();
        paused = 1'b1;
      end
      n = $urandom_range(0, 99);
      if (n < 8 || issued_items < 40) begin
        // Set each band's b0 coefficient near unity so the cascade passes signal
        for (int b = 0; b < NUM_BANDS; b++)
          write_coef(b, SEL_B0, 32'd32768 + 32'($urandom_range(0, 8191)) - 32'd4096);
        for (int m = 0; m < 3; m++)
          process_pair(rand_sample(), rand_sample());
      end else if (n < 80) begin
        // Retune a few coefficients, read some back, then stream pairs
        repeat ($urandom_range(1, 4))
          write_coef($urandom_range(0, NUM_BANDS - 1), $urandom_range(0, 4), rand_coef());
        repeat ($urandom_range(0, 2)) begin
          if ($urandom_range(0, 4) != 0)
            read_coef($urandom_range(0, NUM_BANDS - 1), $urandom_range(0, 4));
          else if ($urandom_range(0, 1) != 0)
            read_coef($urandom_range(NUM_BANDS, 15), $urandom_range(0, 7));
          else
            read_coef($urandom_range(0, 15), $urandom_range(5, 7));
        end
        repeat ($urandom_range(4, 24))
          process_pair(rand_sample(), rand_sample());
      end else begin
        // Noise: arbitrary commands and addresses
        repeat ($urandom_range(1, 4)) send(random_item());
      end
    end

    wait_for_drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.error_count == 0 && sb.pending_outputs.size() == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

  // Output stalls: random modes, plus long hold-offs that back up the block
  initial begin
    int mode;
    int span;
    int phase;
    int holds_done;
    logic [7:0] pattern;
    holds_done = 0;
    out_ready = 1'b0;
    forever begin
      if ((holds_done == 0 && sb.accepted_count >= 400) ||
          (holds_done == 1 && sb.accepted_count >= 1300)) begin
        holds_done++;
        @(negedge clk);
        out_ready = 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
      end else begin
        mode = $urandom_range(0, 3);
        span = $urandom_range(20, 400);
        pattern = 8'($urandom);
        phase = 0;
        repeat (span) begin
          @(negedge clk);
          case (mode)
            0: out_ready = 1'b1;
            1: out_ready = ($urandom_range(0, 3) != 0);
            2: out_ready = ($urandom_range(0, 3) == 0);
            default: out_ready = pattern[phase % 8];
          endcase
          phase++;
        end
      end
    end
  end

  // Check every delivered result
  always @(posedge clk) begin : sample_outputs
    eq_result_t got;
    if (!rst && out_valid && out_ready) begin
      got.kind = result_kind;
      got.left = out_left;
      got.right = out_right;
      got.readback = read_value;
      sb.check_result(got);
    end
  end

  // Timeout
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("Regression FAIL");
    $finish;
  end

endmodule
